// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port checker of the deframer.
// Depends on a clk and an active-low arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check sampled at the rising clock edge, off while in reset
`define SRD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check, off while in reset
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/srd_pkg.sv -----
// Shared types and constants of the servo reply deframer.
// No dependencies; imported by the register file, the frame tracker and the core.
package srd_pkg;

	// Frame format
	localparam int unsigned MAX_FRAME_BYTES = 32;
	localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [7:0]  HEAD_FIRST      = 8'hAA;
	localparam logic [7:0]  HEAD_SECOND     = 8'h55;
	localparam logic [7:0]  STATUS_PAYLOAD  = 8'h11;
	localparam logic [7:0]  LENGTH_EXTRA    = 8'd5;
	localparam logic [7:0]  MIN_FRAME       = 8'd7;

	// Byte positions inside a reply
	localparam logic [POS_W-1:0] POS_DEVICE  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_COMMAND = POS_W'(4);
	localparam int unsigned      TEL_FIRST   = 7;
	localparam int unsigned      TEL_BYTES   = 14;
	localparam logic [POS_W-1:0] STATUS_LEN  =
		POS_W'(int'(STATUS_PAYLOAD) + int'(LENGTH_EXTRA));

	// Register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_DEVICE_ID  = 2'd0,
		REG_MAX_LEN    = 2'd1,
		REG_STATUS_CMD = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_DEVICE   = 2'd2
	} frame_status_t;

	typedef struct packed {
		logic [7:0] own_device_id;
		logic [5:0] max_frame_length;
		logic [7:0] status_command_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  reply_command;
		logic [15:0] firmware_version;
		logic [15:0] current_limit;
		logic [7:0]  speed_limit;
		logic [7:0]  fault_value;
		logic [7:0]  link_check_error;
		logic [15:0] torque_current;
		logic [7:0]  bus_voltage;
		logic [15:0] actual_position;
		logic [15:0] target_position;
	} reply_data_t;

	typedef struct packed {
		logic          is_status_reply;
		frame_status_t frame_status;
		reply_data_t   data;
	} result_t;

endpackage

// ----- hw/rtl/srd_cfg_regs.sv -----
// APB register file of the deframer: device id, length limit, status command.
// Depends on srd_pkg.
module srd_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output srd_pkg::cfg_t cfg
);
	import srd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_device_id       <= 8'd1;
			cfg_q.max_frame_length    <= 6'd32;
			cfg_q.status_command_code <= 8'd0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEVICE_ID:  cfg_q.own_device_id       <= pwdata[7:0];
				REG_MAX_LEN:    cfg_q.max_frame_length    <= pwdata[5:0];
				REG_STATUS_CMD: cfg_q.status_command_code <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_DEVICE_ID:  prdata = {24'd0, cfg_q.own_device_id};
			REG_MAX_LEN:    prdata = {26'd0, cfg_q.max_frame_length};
			REG_STATUS_CMD: prdata = {24'd0, cfg_q.status_command_code};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// ----- hw/rtl/srd_frame_engine.sv -----
// Frame tracker: header hunt, length check, running sum, byte capture and
// result decode for one byte per cycle while go is high. Depends on srd_pkg.
module srd_frame_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [7:0]       rx_byte,
	input  logic             restart,
	input  srd_pkg::cfg_t    cfg,
	output logic             done,
	output srd_pkg::result_t res
);
	import srd_pkg::*;

	// Frame state
	logic [POS_W-1:0] pos_q, flen_q;
	logic [7:0]       sum_q;
	logic [7:0]       dev_q, cmd_q;
	logic [7:0]       tel_q [TEL_BYTES];

	logic [POS_W-1:0] pos, flen, pos_n, flen_n, pos_inc, limit;
	logic [7:0]       sum, sum_n;
	logic [8:0]       len9;
	logic             take, telem;

	// Next-state logic for one byte
	always_comb begin
		pos     = restart ? '0 : pos_q;
		flen    = restart ? '0 : flen_q;
		sum     = restart ? '0 : sum_q;
		pos_n   = pos;
		flen_n  = flen;
		sum_n   = sum;
		take    = 1'b0;
		done    = 1'b0;
		pos_inc = pos + POS_W'(1);
		limit   = (POS_W'(cfg.max_frame_length) < POS_W'(MAX_FRAME_BYTES)) ?
			POS_W'(cfg.max_frame_length) : POS_W'(MAX_FRAME_BYTES);
		len9    = {1'b0, rx_byte} + {1'b0, LENGTH_EXTRA};

		priority if (pos == '0) begin
			take = (rx_byte == HEAD_FIRST);
		end else if (pos == POS_W'(1) && rx_byte != HEAD_SECOND) begin
			// repeated first header byte keeps the hunt one step in
			pos_n = (rx_byte == HEAD_FIRST) ? POS_W'(1) : '0;
		end else begin
			take = 1'b1;
		end

		if (take) begin
			if (pos == '0)
				sum_n = 8'd0;
			if (pos == POS_W'(2))
				sum_n = rx_byte;
			else if (pos > POS_W'(2) && ({1'b0, pos} + (POS_W+1)'(1)) < {1'b0, flen})
				sum_n = sum + rx_byte;
			pos_n = pos_inc;
			if (pos_inc == POS_W'(3)) begin
				flen_n = POS_W'(len9);
				if (len9 > 9'(limit) || len9 < {1'b0, MIN_FRAME}) begin
					pos_n  = '0;
					flen_n = '0;
					sum_n  = 8'd0;
				end
			end else if (pos_inc > POS_W'(3) && pos_inc == flen) begin
				done   = 1'b1;
				pos_n  = '0;
				flen_n = '0;
				sum_n  = 8'd0;
			end
		end
	end

	// Result decode on the last byte
	always_comb begin
		res = '0;
		if (dev_q != cfg.own_device_id)
			res.frame_status = ST_DEVICE;
		else if (sum != rx_byte)
			res.frame_status = ST_CHECKSUM;
		else
			res.frame_status = ST_VALID;
		telem = (res.frame_status == ST_VALID) && (flen == STATUS_LEN) &&
			(cmd_q == cfg.status_command_code);
		res.is_status_reply = telem;
		if (telem) begin
			res.data.target_position  = {tel_q[1],  tel_q[0]};
			res.data.actual_position  = {tel_q[3],  tel_q[2]};
			res.data.bus_voltage      = tel_q[4];
			res.data.torque_current   = {tel_q[6],  tel_q[5]};
			res.data.link_check_error = tel_q[7];
			res.data.fault_value      = tel_q[8];
			res.data.speed_limit      = tel_q[9];
			res.data.current_limit    = {tel_q[11], tel_q[10]};
			res.data.firmware_version = {tel_q[13], tel_q[12]};
		end
		res.data.reply_command = cmd_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			flen_q <= '0;
			sum_q  <= 8'd0;
		end else if (go) begin
			pos_q  <= pos_n;
			flen_q <= flen_n;
			sum_q  <= sum_n;
		end
	end

	// Byte capture at fixed positions
	always_ff @(posedge clk) begin
		if (go && take) begin
			if (pos == POS_DEVICE)
				dev_q <= rx_byte;
			if (pos == POS_COMMAND)
				cmd_q <= rx_byte;
			for (int k = 0; k < TEL_BYTES; k++) begin
				if (pos == POS_W'(TEL_FIRST + k))
					tel_q[k] <= rx_byte;
			end
		end
	end

endmodule

// ----- hw/rtl/servo_reply_deframer_core.sv -----
// A byte accepted into the input register is decoded by the frame tracker, and the
// result word of a frame is captured in the result register on its last byte.
// Throughput: one byte per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// The frame tracker decodes a whole byte in the single stage between them.
// Reset (arst_n low, asynchronous) returns to the header hunt with no result
// pending and the control and configuration registers at their reset values.
module servo_reply_deframer_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] rx_byte
	input  logic          s_tuser,   // [0] restart
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [119:0]  m_tdata,   // target_position, actual_position, bus_voltage,
	                                 // torque_current, link_check_error, fault_value,
	                                 // speed_limit, current_limit, firmware_version,
	                                 // reply_command
	output logic [2:0]    m_tuser,   // [1:0] frame_status, [2] is_status_reply
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import srd_pkg::*;

	cfg_t        cfg;
	result_t     res;
	logic        valid_s1, restart_s1;
	logic [7:0]  byte_s1;
	logic        advance, go, done;
	logic        m_valid_q;
	result_t     m_res_q;

	srd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !m_valid_q || m_tready;
	assign go       = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	srd_frame_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.rx_byte (byte_s1),
		.restart (restart_s1),
		.cfg     (cfg),
		.done    (done),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= go && done;
		end
	end

	always_ff @(posedge clk) begin
		if (go && done)
			m_res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_res_q.data;
	assign m_tuser  = {m_res_q.is_status_reply, m_res_q.frame_status};

endmodule

// ----- hw/rtl/srd_port_checker.sv -----
// Port-level checks of the deframer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module srd_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [119:0]  m_tdata,
	input logic [2:0]    m_tuser
);

	// A stalled result word stays offered
	`SRD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")

	// Telemetry flag only on a frame that passed both checks
	`SRD_ASSERT_IMPLY(a_tel_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == 2'd0, "telemetry on bad frame")

	// Without telemetry only the command byte may be nonzero
	`SRD_ASSERT_IMPLY(a_tel_zero, m_tvalid && !m_tuser[2], m_tdata[111:0] == 112'd0, "stray telemetry")

	// A fresh result follows an accepted input byte
	`SRD_ASSERT_IMPLY(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result without byte")

endmodule

bind servo_reply_deframer_core srd_port_checker u_port_checker (.*);
